// ----- src/mlt_pkg.sv -----
// Shared types and constants of the MAC learning table with aging.
package mlt_pkg;

    // Default depth of the entry store.
    localparam int TABLE_ENTRIES_DEF = 256;
    // Number of switch ports; a learn on a higher port number is ignored.
    localparam int PORT_COUNT = 16;

    // Field widths.
    localparam int ADDR_W    = 48;
    localparam int PORT_W    = 4;
    localparam int STAMP_W   = 16;
    localparam int TIMEOUT_W = 8;
    localparam int AGED_W    = 9;
    localparam int OP_W      = 2;

    // Stream word widths.
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 16;

    // Reset value of the aging timeout in seconds.
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd30;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_LEARN  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    // One slot of the table as held in memory.
    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  addr;
        logic [PORT_W-1:0]  port;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    // Verdict of the compare unit on one slot.
    typedef struct packed {
        logic match;
        logic free;
        logic expired;
    } t_cmp;

    // One result word.
    typedef struct packed {
        logic              hit;
        logic [PORT_W-1:0] found_port;
        logic              full;
        logic [AGED_W-1:0] aged;
    } t_result;

    // Sequencer status seen at the top level.
    typedef struct packed {
        logic clearing;
        logic busy;
    } t_status;

endpackage

// ----- src/mac_learning_table_aging_top.sv -----
// Top level of the MAC learning table with aging: stream ports and timeout register.
//
// The table holds TABLE_ENTRIES slots in one memory with a registered read port.
// After reset a clearing pass writes every slot, during which no word is
// accepted. A lookup, learn or tick then walks the slots one per cycle through
// one compare unit: a tick visits every slot before its result word, a lookup
// or learn ends early at its hit, and an unused operation code or a learn on a
// port out of range skips the scan. A new word is taken while the previous
// result still waits on the master side.
module mac_learning_table_aging_top #(
    parameter int TABLE_ENTRIES = mlt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [mlt_pkg::TIMEOUT_W-1:0]     i_cfg_wr_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // mac_address [47:0], port_number [51:48], zero pad [55:52]
    input  logic [mlt_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // operation [1:0]
    input  logic [mlt_pkg::OP_W-1:0]          s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // hit [0], found_port [4:1], table_full [5], aged_count [14:6], zero pad [15]
    output logic [mlt_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
    import mlt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic [TIMEOUT_W-1:0] r_timeout;
    t_result              result;
    t_status              status;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    t_entry               wr_data;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_idx;
    t_entry               rd_data;

    // Aging timeout register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            r_timeout <= i_cfg_wr_data;
        end
    end

    mlt_mem #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_idx  (wr_idx),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_idx  (rd_idx),
        .o_rd_data (rd_data)
    );

    mlt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (s_axis_tvalid),
        .o_s_ready  (s_axis_tready),
        .i_s_op     (s_axis_tuser),
        .i_s_addr   (s_axis_tdata[ADDR_W-1:0]),
        .i_s_port   (s_axis_tdata[ADDR_W+PORT_W-1:ADDR_W]),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_m_result (result),
        .i_timeout  (r_timeout),
        .o_wr_en    (wr_en),
        .o_wr_idx   (wr_idx),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_idx   (rd_idx),
        .i_rd_data  (rd_data),
        .o_status   (status)
    );

    // Pack the result word.
    assign m_axis_tdata = {1'b0, result.aged, result.full, result.found_port, result.hit};

    // No word is taken during the clearing pass or while a scan runs.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.clearing || status.busy) |-> !s_axis_tready)
        else $error("word accepted while the table is busy");

    // An accepted word always leaves the sequencer busy in the cycle after.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> status.busy)
        else $error("sequencer not busy after an accepted word");

    // A dropped learn never reports a hit.
    a_full_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(result.hit && result.full))
        else $error("result flags both hit and table full");

    // Removals are only reported by a tick, which has no hit or drop.
    a_aged_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (result.aged != '0)) |-> (!result.hit && !result.full))
        else $error("aged count reported together with lookup or learn flags");

endmodule

// ----- src/mlt_mem.sv -----
// Entry store: one write port and one registered read port.
module mlt_mem #(
    parameter int TABLE_ENTRIES = mlt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] i_wr_idx,
    input  mlt_pkg::t_entry                  i_wr_data,
    input  logic                             i_rd_en,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] i_rd_idx,
    output mlt_pkg::t_entry                  o_rd_data
);
    import mlt_pkg::*;

    t_entry r_mem [TABLE_ENTRIES];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    // Read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_idx];
        end
    end

endmodule

// ----- src/mlt_cmp.sv -----
// Compare unit: address match, free slot and age check on one slot.
module mlt_cmp (
    input  mlt_pkg::t_entry                     i_entry,
    input  logic [mlt_pkg::ADDR_W-1:0]          i_addr,
    input  logic [mlt_pkg::STAMP_W-1:0]         i_seconds,
    input  logic [mlt_pkg::TIMEOUT_W-1:0]       i_timeout,
    output mlt_pkg::t_cmp                       o_cmp
);
    import mlt_pkg::*;

    logic [STAMP_W-1:0] age;

    // Age wraps with the seconds counter.
    assign age = i_seconds - i_entry.stamp;

    assign o_cmp.match   = i_entry.valid && (i_entry.addr == i_addr);
    assign o_cmp.free    = !i_entry.valid;
    assign o_cmp.expired = i_entry.valid &&
                           (age > {{(STAMP_W-TIMEOUT_W){1'b0}}, i_timeout});

endmodule

// ----- src/mlt_ctrl.sv -----
// Sequencer: walks the entry store for each lookup, learn or tick and holds the result.
module mlt_ctrl #(
    parameter int TABLE_ENTRIES = mlt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_valid,
    output logic                             o_s_ready,
    input  logic [mlt_pkg::OP_W-1:0]         i_s_op,
    input  logic [mlt_pkg::ADDR_W-1:0]       i_s_addr,
    input  logic [mlt_pkg::PORT_W-1:0]       i_s_port,
    output logic                             o_m_valid,
    input  logic                             i_m_ready,
    output mlt_pkg::t_result                 o_m_result,
    input  logic [mlt_pkg::TIMEOUT_W-1:0]    i_timeout,
    output logic                             o_wr_en,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_wr_idx,
    output mlt_pkg::t_entry                  o_wr_data,
    output logic                             o_rd_en,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_rd_idx,
    input  mlt_pkg::t_entry                  i_rd_data,
    output mlt_pkg::t_status                 o_status
);
    import mlt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [8:0] PORT_LIMIT = 9'(PORT_COUNT);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state             r_state;
    logic [IDX_W-1:0]   r_idx;
    logic               r_pend;
    logic [IDX_W-1:0]   r_pend_idx;
    logic [OP_W-1:0]    r_op;
    logic [ADDR_W-1:0]  r_addr;
    logic [PORT_W-1:0]  r_port;
    logic [STAMP_W-1:0] r_seconds;
    logic               r_free_vld;
    logic [IDX_W-1:0]   r_free_idx;
    logic [CNT_W-1:0]   r_aged;
    t_result            r_res;
    t_result            r_out;
    logic               r_out_valid;

    t_cmp   cmp;
    t_entry learn_word;
    logic   pend_last;
    logic   port_ok;

    // Shared compare unit on the slot just read.
    mlt_cmp u_cmp (
        .i_entry   (i_rd_data),
        .i_addr    (r_addr),
        .i_seconds (r_seconds),
        .i_timeout (i_timeout),
        .o_cmp     (cmp)
    );

    assign pend_last = (r_pend_idx == LAST_IDX);
    assign port_ok   = ({5'd0, i_s_port} < PORT_LIMIT);

    assign learn_word.valid = 1'b1;
    assign learn_word.addr  = r_addr;
    assign learn_word.port  = r_port;
    assign learn_word.stamp = r_seconds;

    // Memory read follows the scan index.
    assign o_rd_en  = (r_state == S_SCAN);
    assign o_rd_idx = r_idx;

    // Memory writes: clearing pass, learn refresh or fill, and removal on a tick.
    always_comb begin
        o_wr_en   = 1'b0;
        o_wr_idx  = r_pend_idx;
        o_wr_data = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_wr_en  = 1'b1;
                o_wr_idx = r_idx;
            end
            S_SCAN: begin
                if (r_pend) begin
                    case (r_op)
                        OP_LEARN: begin
                            if (cmp.match) begin
                                o_wr_en   = 1'b1;
                                o_wr_data = learn_word;
                            end else if (pend_last && (r_free_vld || cmp.free)) begin
                                o_wr_en   = 1'b1;
                                o_wr_idx  = r_free_vld ? r_free_idx : r_pend_idx;
                                o_wr_data = learn_word;
                            end
                        end
                        OP_TICK: begin
                            o_wr_en = cmp.expired;
                        end
                        default: begin
                            o_wr_en = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                o_wr_en = 1'b0;
            end
        endcase
    end

    // State, scan bookkeeping and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_seconds   <= '0;
            r_free_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LAST_IDX) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_valid) begin
                        r_op       <= i_s_op;
                        r_addr     <= i_s_addr;
                        r_port     <= i_s_port;
                        r_res      <= '0;
                        r_aged     <= '0;
                        r_free_vld <= 1'b0;
                        r_idx      <= '0;
                        r_pend     <= 1'b0;
                        case (i_s_op)
                            OP_LOOKUP: begin
                                r_state <= S_SCAN;
                            end
                            OP_LEARN: begin
                                r_state <= port_ok ? S_SCAN : S_FINISH;
                            end
                            OP_TICK: begin
                                r_seconds <= r_seconds + 1'b1;
                                r_state   <= S_SCAN;
                            end
                            default: begin
                                r_state <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_idx != LAST_IDX) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    r_pend     <= 1'b1;
                    r_pend_idx <= r_idx;
                    if (r_pend) begin
                        case (r_op)
                            OP_LOOKUP: begin
                                if (cmp.match) begin
                                    r_res.hit        <= 1'b1;
                                    r_res.found_port <= i_rd_data.port;
                                    r_pend           <= 1'b0;
                                    r_state          <= S_FINISH;
                                end else if (pend_last) begin
                                    r_pend  <= 1'b0;
                                    r_state <= S_FINISH;
                                end
                            end
                            OP_LEARN: begin
                                if (cmp.match) begin
                                    r_res.hit <= 1'b1;
                                    r_pend    <= 1'b0;
                                    r_state   <= S_FINISH;
                                end else begin
                                    if (cmp.free && !r_free_vld) begin
                                        r_free_vld <= 1'b1;
                                        r_free_idx <= r_pend_idx;
                                    end
                                    if (pend_last) begin
                                        r_res.full <= !(r_free_vld || cmp.free);
                                        r_pend     <= 1'b0;
                                        r_state    <= S_FINISH;
                                    end
                                end
                            end
                            OP_TICK: begin
                                r_aged <= r_aged + CNT_W'(cmp.expired);
                                if (pend_last) begin
                                    r_res.aged <= AGED_W'(r_aged + CNT_W'(cmp.expired));
                                    r_pend     <= 1'b0;
                                    r_state    <= S_FINISH;
                                end
                            end
                            default: begin
                                r_pend  <= 1'b0;
                                r_state <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid || i_m_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_ready  = (r_state == S_IDLE);
    assign o_m_valid  = r_out_valid;
    assign o_m_result = r_out;

    assign o_status.clearing = (r_state == S_CLEAR);
    assign o_status.busy     = (r_state == S_SCAN) || (r_state == S_FINISH);

endmodule

// ----- tb/mac_learning_table_aging_top_test.sv -----
// Self-checking testbench for the MAC learning table with aging: directed words, then random traffic.
`timescale 1ns / 100ps

module mac_learning_table_aging_top_test;
    import mlt_pkg::*;

    localparam int TABLE_SIZE = TABLE_ENTRIES_DEF;
    localparam int POOL_SIZE = 40;
    localparam int REPORT_LIMIT = 10;
    localparam int IDLE_PCT = 27;
    localparam int TOTAL_WORDS = 1200;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [ADDR_W-1:0] MAC_ZERO = '0;
    localparam logic [ADDR_W-1:0] MAC_ONES = '1;
    localparam t_result ALL_ZERO = '0;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [TIMEOUT_W-1:0] i_cfg_wr_data;
    logic s_axis_tvalid;
    logic s_axis_tready;
    // mac_address [47:0], port_number [51:48], zero pad [55:52]
    logic [S_TDATA_W-1:0] s_axis_tdata;
    // operation [1:0]
    logic [OP_W-1:0] s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // hit [0], found_port [4:1], table_full [5], aged_count [14:6], zero pad [15]
    logic [M_TDATA_W-1:0] m_axis_tdata;

    mac_learning_table_aging_top #(
        .TABLE_ENTRIES(TABLE_SIZE)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Forwarding table as the testbench expects it to be.
    logic               fdb_valid [TABLE_SIZE];
    logic [ADDR_W-1:0]  fdb_addr [TABLE_SIZE];
    logic [PORT_W-1:0]  fdb_port [TABLE_SIZE];
    logic [STAMP_W-1:0] fdb_stamp [TABLE_SIZE];
    logic [STAMP_W-1:0] fdb_seconds;
    logic [TIMEOUT_W-1:0] fdb_timeout;

    t_result pending_results [$];
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    int fail_count = 0;
    int words_sent = 0;
    int results_seen = 0;
    int lookup_hits = 0;
    int learn_drops = 0;
    int widest_sweep = 0;
    bit no_gaps = 1'b0;

    // Directed words; a set use_typed flag means the expected result is written out.
    typedef struct {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] mac;
        logic [PORT_W-1:0] prt;
        bit                use_typed;
        t_result           want;
    } t_probe_row;

    localparam int PROBE_ROWS = 17;
    t_probe_row probe_rows [PROBE_ROWS] = '{
        '{OP_LOOKUP, MAC_ZERO, 4'd0, 1'b1, '{1'b0, 4'd0, 1'b0, 9'd0}},
        '{OP_LOOKUP, MAC_ONES, 4'd15, 1'b1, '{1'b0, 4'd0, 1'b0, 9'd0}},
        '{OP_TICK, 48'h0123_4567_89AB, 4'd3, 1'b1, '{1'b0, 4'd0, 1'b0, 9'd0}},
        '{OP_UNUSED, MAC_ONES, 4'd15, 1'b1, '{1'b0, 4'd0, 1'b0, 9'd0}},
        '{OP_LEARN, MAC_ZERO, 4'd0, 1'b1, '{1'b0, 4'd0, 1'b0, 9'd0}},
        '{OP_LEARN, MAC_ONES, 4'd15, 1'b1, '{1'b0, 4'd0, 1'b0, 9'd0}},
        '{OP_LOOKUP, MAC_ZERO, 4'd9, 1'b1, '{1'b1, 4'd0, 1'b0, 9'd0}},
        '{OP_LOOKUP, MAC_ONES, 4'd0, 1'b1, '{1'b1, 4'd15, 1'b0, 9'd0}},
        '{OP_LEARN, MAC_ZERO, 4'd15, 1'b1, '{1'b1, 4'd0, 1'b0, 9'd0}},
        '{OP_LOOKUP, MAC_ZERO, 4'd0, 1'b1, '{1'b1, 4'd15, 1'b0, 9'd0}},
        '{OP_LEARN, 48'hAAAA_AAAA_AAAA, 4'd10, 1'b1, '{1'b0, 4'd0, 1'b0, 9'd0}},
        '{OP_LEARN, 48'h5555_5555_5555, 4'd5, 1'b1, '{1'b0, 4'd0, 1'b0, 9'd0}},
        '{OP_LOOKUP, 48'h5555_5555_5554, 4'd5, 1'b1, '{1'b0, 4'd0, 1'b0, 9'd0}},
        '{OP_LOOKUP, 48'hAAAA_AAAA_AAAA, 4'd1, 1'b1, '{1'b1, 4'd10, 1'b0, 9'd0}},
        '{OP_TICK, MAC_ONES, 4'd15, 1'b0, ALL_ZERO},
        '{OP_UNUSED, MAC_ZERO, 4'd0, 1'b1, '{1'b0, 4'd0, 1'b0, 9'd0}},
        '{OP_LOOKUP, 48'h5555_5555_5555, 4'd0, 1'b0, ALL_ZERO}
    };

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Applies one word to the expected table and returns the result it should produce.
    function automatic t_result fdb_apply(input logic [OP_W-1:0] op,
                                          input logic [ADDR_W-1:0] mac,
                                          input logic [PORT_W-1:0] prt);
        t_result res;
        int slot;
        int free_slot;
        logic [STAMP_W-1:0] age;
        res = '0;
        slot = -1;
        free_slot = -1;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (slot < 0 && fdb_valid[i] && fdb_addr[i] == mac) slot = i;
            if (free_slot < 0 && !fdb_valid[i]) free_slot = i;
        end
        case (op)
            OP_LOOKUP: begin
                if (slot >= 0) begin
                    res.hit = 1'b1;
                    res.found_port = fdb_port[slot];
                end
            end
            OP_LEARN: begin
                if (int'(prt) < PORT_COUNT) begin
                    if (slot >= 0) begin
                        res.hit = 1'b1;
                        fdb_port[slot] = prt;
                        fdb_stamp[slot] = fdb_seconds;
                    end else if (free_slot >= 0) begin
                        fdb_valid[free_slot] = 1'b1;
                        fdb_addr[free_slot] = mac;
                        fdb_port[free_slot] = prt;
                        fdb_stamp[free_slot] = fdb_seconds;
                    end else begin
                        res.full = 1'b1;
                    end
                end
            end
            OP_TICK: begin
                // The clock advances first, then every stale slot is dropped.
                fdb_seconds = fdb_seconds + 16'd1;
                for (int i = 0; i < TABLE_SIZE; i++) begin
                    age = fdb_seconds - fdb_stamp[i];
                    if (fdb_valid[i] && age > STAMP_W'(fdb_timeout)) begin
                        fdb_valid[i] = 1'b0;
                        res.aged = res.aged + 9'd1;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] random_mac();
        logic [31:0] lo;
        logic [31:0] hi;
        lo = $urandom;
        hi = $urandom;
        return {hi[15:0], lo};
    endfunction

    // Mostly addresses from a small pool so that hits and refreshes are common.
    function automatic logic [ADDR_W-1:0] pick_address();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60) return addr_pool[$urandom_range(POOL_SIZE - 1)];
        if (sel < 64) return MAC_ZERO;
        if (sel < 68) return MAC_ONES;
        if (sel < 72) return MAC_ZERO | (48'h1 << $urandom_range(ADDR_W - 1));
        return random_mac();
    endfunction

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Offers one word on the slave side and records its expected result once taken.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] mac,
                             input logic [PORT_W-1:0] prt, input bit use_typed,
                             input t_result typed_res);
        t_result res;
        @(negedge i_clk);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {4'b0, prt, mac};
        s_axis_tuser = op;
        do @(posedge i_clk); while (!s_axis_tready);
        res = fdb_apply(op, mac, prt);
        if (op == OP_LOOKUP && res.hit) lookup_hits++;
        if (res.full) learn_drops++;
        if (int'(res.aged) > widest_sweep) widest_sweep = int'(res.aged);
        pending_results.push_back(use_typed ? typed_res : res);
        words_sent++;
    endtask

    task automatic random_word(input int tick_pct);
        logic [OP_W-1:0] op;
        int pick;
        pick = $urandom_range(99);
        if (pick < tick_pct) op = OP_TICK;
        else if (pick < tick_pct + 4) op = OP_UNUSED;
        else if (pick < tick_pct + 52) op = OP_LEARN;
        else op = OP_LOOKUP;
        send_word(op, pick_address(), PORT_W'($urandom_range(15)), 1'b0, ALL_ZERO);
    endtask

    // Stops offering words and waits until every expected result has come back.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_timeout(input logic [TIMEOUT_W-1:0] secs);
        drain();
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_wr_data = secs;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        fdb_timeout = secs;
    endtask

    // Master-side back-pressure.
    always @(negedge i_clk) begin
        m_axis_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end

    // Result checker: every word taken on the master side must match the oldest expectation.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.hit = m_axis_tdata[0];
            got.found_port = m_axis_tdata[4:1];
            got.full = m_axis_tdata[5];
            got.aged = m_axis_tdata[14:6];
            results_seen++;
            if (pending_results.size() == 0) begin
                flag_error($sformatf("result word 0x%h with no word outstanding", m_axis_tdata));
            end else begin
                want = pending_results.pop_front();
                if (got.hit !== want.hit || got.found_port !== want.found_port ||
                    got.full !== want.full || got.aged !== want.aged) begin
                    flag_error($sformatf(
                        "result %0d: expected hit=%0b port=%0d full=%0b aged=%0d, %s",
                        results_seen, want.hit, want.found_port, want.full, want.aged,
                        $sformatf("got hit=%0b port=%0d full=%0b aged=%0d",
                                  got.hit, got.found_port, got.full, got.aged)));
                end
            end
        end
    end

    // Watchdog.
    initial begin
        #12_000_000;
        $display("Timeout: %0d words sent, %0d results seen", words_sent, results_seen);
        $display("Test completed with failures");
        $finish;
    end

    // Main sequence.
    initial begin
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = TIMEOUT_RESET;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_LOOKUP;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            fdb_valid[i] = 1'b0;
            fdb_addr[i] = '0;
            fdb_port[i] = '0;
            fdb_stamp[i] = '0;
        end
        fdb_seconds = '0;
        fdb_timeout = TIMEOUT_RESET;
        for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = random_mac();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words on the empty table with the reset timeout.
        for (int r = 0; r < PROBE_ROWS; r++) begin
            send_word(probe_rows[r].op, probe_rows[r].mac, probe_rows[r].prt,
                      probe_rows[r].use_typed, probe_rows[r].want);
        end

        // Random traffic under the reset timeout.
        repeat (200) random_word(12);

        // Shortest nonzero timeout: entries age out quickly.
        set_timeout(8'd1);
        repeat (150) random_word(15);

        // A zero timeout lets every tick drop all entries;
        // the closing tick leaves the table empty.
        set_timeout(8'd0);
        repeat (100) random_word(15);
        send_word(OP_TICK, random_mac(), 4'd0, 1'b0, ALL_ZERO);

        // Longest timeout: fill the table past its capacity without gaps on either side.
        set_timeout(8'd255);
        no_gaps = 1'b1;
        repeat (TABLE_SIZE + 14) begin
            send_word(OP_LEARN, random_mac(), PORT_W'($urandom_range(15)), 1'b0, ALL_ZERO);
        end
        repeat (20) random_word(0);
        no_gaps = 1'b0;

        // All slots share one stamp, so the second tick clears the full table at once.
        set_timeout(8'd1);
        repeat (3) send_word(OP_TICK, pick_address(), PORT_W'($urandom_range(15)), 1'b0,
                             ALL_ZERO);

        // Remaining traffic under a random moderate timeout.
        set_timeout(TIMEOUT_W'($urandom_range(2, 40)));
        while (words_sent < TOTAL_WORDS) random_word(10);

        // Wait for the last results, then watch for any stray word.
        drain();
        repeat (TABLE_SIZE + 16) @(posedge i_clk);

        $display("Sent %0d words and checked %0d results over timeouts 30, 1, 0, 255 and %0d.",
                 words_sent, results_seen, fdb_timeout);
        $display("Lookup hits %0d, dropped learns %0d, largest sweep %0d entries, mismatches %0d.",
                 lookup_hits, learn_drops, widest_sweep, fail_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
